// ===== rtl/swa_pkg.sv =====
// ----------------------------------------------------------------------------
// swa_pkg: shared types and constants for the sliding window average
// Controller states, command and status bundles, register map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swa_pkg;

  localparam int WL_W       = 7;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [WL_W-1:0] WL_RESET = 7'd3;

  typedef enum logic {
    REG_WINDOW_LENGTH = 1'b0,
    REG_UNUSED        = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DELIVER
  } swa_state_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic div_start;
    logic out_load;
  } swa_cmd_t;

  typedef struct packed {
    logic produce;
    logic div_done;
    logic out_free;
  } swa_sts_t;

endpackage

`default_nettype wire

// ===== rtl/swa_ram.sv =====
// ----------------------------------------------------------------------------
// swa_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/swa_div.sv =====
// ----------------------------------------------------------------------------
// swa_div: iterative signed-by-unsigned divider
// Restoring division, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swa_div #(
  parameter int SUM_W = 22,
  parameter int DIV_W = 7,
  parameter int Q_W   = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output      logic             done,
  output      logic [Q_W-1:0]   quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  den_r, den_nxt;
  logic              neg_r, neg_nxt;

  logic [SUM_W-1:0]  mag;
  logic [DIV_W:0]    shifted;
  logic [DIV_W+1:0]  diff;
  logic [SUM_W-1:0]  signed_quo;

  assign mag     = dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
  assign shifted = {rem_r, quo_r[SUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = STEP_W'(SUM_W);
      quo_nxt  = mag;
      rem_nxt  = '0;
      den_nxt  = divisor;
      neg_nxt  = dividend[SUM_W-1];
    end else if (busy_r) begin
      if (diff[DIV_W+1]) begin
        rem_nxt = shifted[DIV_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end else begin
        rem_nxt = diff[DIV_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign signed_quo = neg_r ? SUM_W'(-quo_r) : quo_r;
  assign quotient   = signed_quo[Q_W-1:0];
  assign done       = done_r;

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < den_r))
    else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

// ===== rtl/swa_datapath.sv =====
// ----------------------------------------------------------------------------
// swa_datapath: sample ring, running sum, divider and result register
// Holds the series state and the window length register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swa_datapath
  import swa_pkg::*;
#(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire swa_cmd_t               cmd,
  output      swa_sts_t               sts,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                   in_last_sample,
  input  wire logic                   cfg_we,
  input  wire logic [WL_W-1:0]        cfg_wdata,
  output      logic [WL_W-1:0]        window_length,
  output      logic                   out_valid,
  input  wire logic                   out_ready,
  output      logic [SAMPLE_BITS-1:0] out_average,
  output      logic                   out_series_end
);

  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int EXT_W = SUM_W - SAMPLE_BITS;

  logic [WL_W-1:0]        wl_r, wl_nxt;
  logic [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic                   last_r, last_nxt;
  logic [IDX_W-1:0]       pos_r, pos_nxt;
  logic [IDX_W-1:0]       ring_pos_r, ring_pos_nxt;
  logic [CNT_W-1:0]       seen_r, seen_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SAMPLE_BITS-1:0] avg_r, avg_nxt;
  logic                   end_r, end_nxt;
  logic                   valid_r, valid_nxt;

  logic [CNT_W-1:0]       w_eff;
  logic [IDX_W-1:0]       pos_sel;
  logic [CNT_W-1:0]       pos_inc;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic [SUM_W-1:0]       old_ext;
  logic [SUM_W-1:0]       new_ext;
  logic [SUM_W-1:0]       sum_new;
  logic [CNT_W-1:0]       seen_new;
  logic                   div_done;
  logic [SAMPLE_BITS-1:0] quotient;

  always_comb begin
    if (wl_r == '0) begin
      w_eff = CNT_W'(1);
    end else if (32'(wl_r) > 32'(MAX_WINDOW)) begin
      w_eff = CNT_W'(MAX_WINDOW);
    end else begin
      w_eff = CNT_W'(wl_r);
    end
  end

  assign pos_sel  = (CNT_W'(ring_pos_r) >= w_eff) ? '0 : ring_pos_r;
  assign pos_inc  = CNT_W'(pos_r) + CNT_W'(1);
  assign old_ext  = (seen_r >= w_eff) ? {{EXT_W{old_sample[SAMPLE_BITS-1]}}, old_sample} : '0;
  assign new_ext  = {{EXT_W{sample_r[SAMPLE_BITS-1]}}, sample_r};
  assign sum_new  = sum_r - old_ext + new_ext;
  assign seen_new = (seen_r < w_eff) ? seen_r + CNT_W'(1) : seen_r;

  swa_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (pos_r),
    .wdata (sample_r),
    .re    (cmd.accept),
    .raddr (pos_sel),
    .rdata (old_sample)
  );

  swa_div #(
    .SUM_W (SUM_W),
    .DIV_W (CNT_W),
    .Q_W   (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_new),
    .divisor  (w_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    wl_nxt       = wl_r;
    sample_nxt   = sample_r;
    last_nxt     = last_r;
    pos_nxt      = pos_r;
    ring_pos_nxt = ring_pos_r;
    seen_nxt     = seen_r;
    sum_nxt      = sum_r;
    avg_nxt      = avg_r;
    end_nxt      = end_r;
    valid_nxt    = valid_r & ~out_ready;

    if (cmd.accept) begin
      sample_nxt = in_sample;
      last_nxt   = in_last_sample;
      pos_nxt    = pos_sel;
    end

    if (cmd.update) begin
      if (last_r) begin
        ring_pos_nxt = '0;
        seen_nxt     = '0;
        sum_nxt      = '0;
      end else begin
        ring_pos_nxt = (pos_inc >= w_eff) ? '0 : pos_inc[IDX_W-1:0];
        seen_nxt     = seen_new;
        sum_nxt      = sum_new;
      end
    end

    if (cmd.out_load) begin
      avg_nxt   = quotient;
      end_nxt   = last_r;
      valid_nxt = 1'b1;
    end

    if (cfg_we) begin
      wl_nxt       = cfg_wdata;
      ring_pos_nxt = '0;
      seen_nxt     = '0;
      sum_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r       <= WL_RESET;
      ring_pos_r <= '0;
      seen_r     <= '0;
      sum_r      <= '0;
      valid_r    <= 1'b0;
    end else begin
      wl_r       <= wl_nxt;
      ring_pos_r <= ring_pos_nxt;
      seen_r     <= seen_nxt;
      sum_r      <= sum_nxt;
      valid_r    <= valid_nxt;
    end
    sample_r <= sample_nxt;
    last_r   <= last_nxt;
    pos_r    <= pos_nxt;
    avg_r    <= avg_nxt;
    end_r    <= end_nxt;
  end

  assign sts.produce  = seen_new >= w_eff;
  assign sts.div_done = div_done;
  assign sts.out_free = ~valid_r | out_ready;

  assign window_length  = wl_r;
  assign out_valid      = valid_r;
  assign out_average    = avg_r;
  assign out_series_end = end_r;

`ifndef SYNTHESIS
  a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= w_eff)
    else $error("sample count exceeds window length");

  a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (seen_r == '0 && sum_r == '0))
    else $error("window length write did not restart the series");
`endif

endmodule

`default_nettype wire

// ===== rtl/swa_ctrl.sv =====
// ----------------------------------------------------------------------------
// swa_ctrl: sequencing for the sliding window average
// Steps one sample through ring update, division and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swa_ctrl
  import swa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output      logic     in_ready,
  input  wire swa_sts_t sts,
  output      swa_cmd_t cmd
);

  swa_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = sts.produce ? ST_DIVIDE : ST_IDLE;
      end
      ST_DIVIDE: begin
        if (sts.div_done) begin
          state_nxt = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.update    = 1'b0;
    cmd.div_start = 1'b0;
    cmd.out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_UPDATE: begin
        cmd.update    = 1'b1;
        cmd.div_start = sts.produce;
      end
      ST_DIVIDE: begin
      end
      ST_DELIVER: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid) |=> (state_r == ST_UPDATE))
    else $error("accepted transfer not followed by update");

  a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == ST_DIVIDE))
    else $error("divider finished outside divide state");
`endif

endmodule

`default_nettype wire

// ===== rtl/sliding_window_average.sv =====
// ----------------------------------------------------------------------------
// sliding_window_average: simple moving average over a configurable window
//
// Input channel (in_valid/in_ready): one signed sample per transfer, with
// in_last_sample marking the final sample of a series. Output channel
// (out_valid/out_ready): one average per sample once the window is full,
// truncated toward zero, with out_series_end copied from in_last_sample.
// A last sample clears the series after its own result, if any.
// Configuration: APB write of window_length at address 0 restarts the series;
// zero acts as one and values above MAX_WINDOW saturate. Reset value is 3.
// A sample with no result passes the accept and update states; a sample with
// a result then waits on the divider (one quotient bit per cycle) and delivery.
// One sample is in flight at a time; after a sample with a result the next
// transfer can be taken in the cycle after the result is loaded.
// Reset clears the series and the output valid flag; the sample ring needs no
// clearing. A stalled receiver holds the result in the output register; the
// next sample is still taken and waits only when its own result is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_average
  import swa_pkg::*;
#(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output      logic                   in_ready,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                   in_last_sample,
  output      logic                   out_valid,
  input  wire logic                   out_ready,
  output      logic [SAMPLE_BITS-1:0] out_average,
  output      logic                   out_series_end,
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output      logic [CFG_DATA_W-1:0]  cfg_prdata,
  output      logic                   cfg_pready
);

  swa_cmd_t         cmd;
  swa_sts_t         sts;
  logic             cfg_we;
  logic [WL_W-1:0]  window_length;
  reg_idx_t         reg_idx;

  assign reg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready
                      & (reg_idx == REG_WINDOW_LENGTH);

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW_LENGTH: cfg_prdata = CFG_DATA_W'(window_length);
      REG_UNUSED:        cfg_prdata = '0;
      default:           cfg_prdata = '0;
    endcase
  end

  swa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swa_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_sample      (in_sample),
    .in_last_sample (in_last_sample),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_pwdata[WL_W-1:0]),
    .window_length  (window_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_average    (out_average),
    .out_series_end (out_series_end)
  );

endmodule

`default_nettype wire

// ===== dv/sliding_window_average_checker.sv =====
// ----------------------------------------------------------------------------
// sliding_window_average_checker: result predictor and scoreboard
// Watches the sample, average and register ports of the moving average.
// Every sample transfer advances a local copy of the window ring and sum;
// once the window is full it also queues the expected average. Averages are
// compared with the oldest queued one, register reads with the last write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_average_checker
  import swa_pkg::*;
#(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_last_sample,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [SAMPLE_BITS-1:0] out_average,
  input  logic                   out_series_end,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  input  logic [CFG_DATA_W-1:0]  cfg_prdata,
  input  logic                   cfg_pready,
  output int                     mismatches,
  output int                     pending_results
);

  localparam logic [CFG_ADDR_W-1:0] WL_ADDR = CFG_ADDR_W'(4 * int'(REG_WINDOW_LENGTH));
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] average;
    logic                   series_end;
  } average_t;

  average_t                      average_q[$];
  logic [WL_W-1:0]               window_reg;
  logic signed [SAMPLE_BITS-1:0] window_ring[MAX_WINDOW];
  int                            ring_slot;
  int                            series_count;
  longint                        window_sum;

  initial begin
    mismatches      = 0;
    pending_results = 0;
  end

  function automatic longint active_window();
    if (window_reg == '0) begin
      return 1;
    end
    if (int'(window_reg) > MAX_WINDOW) begin
      return MAX_WINDOW;
    end
    return longint'(window_reg);
  endfunction

  task automatic restart_series();
    ring_slot    = 0;
    series_count = 0;
    window_sum   = 0;
  endtask

  task automatic take_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic last);
    longint   w;
    int       slot;
    longint   mean;
    average_t exp_avg;
    w    = active_window();
    slot = ring_slot;
    if (slot >= w) begin
      slot = 0;
    end
    if (series_count >= w) begin
      window_sum -= window_ring[slot];
    end
    window_ring[slot] = value;
    window_sum += value;
    ring_slot = (slot + 1 >= w) ? 0 : slot + 1;
    if (series_count < w) begin
      series_count++;
    end
    if (series_count >= w) begin
      mean                = window_sum / w;
      exp_avg.average     = mean[SAMPLE_BITS-1:0];
      exp_avg.series_end  = last;
      average_q.push_back(exp_avg);
    end
    if (last) begin
      restart_series();
    end
  endtask

  always @(posedge clk) begin
    average_t exp_avg;
    if (!rst_n) begin
      window_reg = WL_RESET;
      restart_series();
      average_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (average_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: unexpected average transfer: average %0d series_end %0b",
                     $realtime, $signed(out_average), out_series_end);
          end
        end else begin
          exp_avg = average_q.pop_front();
          if (out_average !== exp_avg.average || out_series_end !== exp_avg.series_end) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: average exp %0d/%0b act %0d/%0b (average/series_end)",
                       $realtime, $signed(exp_avg.average), exp_avg.series_end,
                       $signed(out_average), out_series_end);
            end
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == WL_ADDR) begin
        if (cfg_pwrite) begin
          window_reg = cfg_pwdata[WL_W-1:0];
          restart_series();
        end else if (cfg_prdata !== CFG_DATA_W'(window_reg)) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: window_length read exp %0d act %0d",
                     $realtime, window_reg, cfg_prdata);
          end
        end
      end
      if (in_valid && in_ready) begin
        take_sample($signed(in_sample), in_last_sample);
      end
    end
    pending_results = average_q.size();
  end

endmodule

// ===== dv/tb_sliding_window_average.sv =====
// ----------------------------------------------------------------------------
// tb_sliding_window_average: testbench for the sliding window average
// Drives directed and random sample series with random idle gaps on both
// channels, reprograms window_length between series at small, large,
// zero and saturating values, and takes the verdict from the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sliding_window_average;
  import swa_pkg::*;

  localparam int MAX_WINDOW    = 64;
  localparam int SAMPLE_BITS   = 16;
  localparam int TARGET_ITEMS  = 1200;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 2000;

  localparam logic [CFG_ADDR_W-1:0]  WL_ADDR    = CFG_ADDR_W'(4 * int'(REG_WINDOW_LENGTH));
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam int EDGE_WINDOWS[6] = '{1, 64, 127, 65, 2, 63};

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic                   in_last_sample;
  logic                   out_valid;
  logic                   out_ready;
  logic [SAMPLE_BITS-1:0] out_average;
  logic                   out_series_end;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_ADDR_W-1:0]  cfg_paddr;
  logic [CFG_DATA_W-1:0]  cfg_pwdata;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  int mismatches;
  int pending_results;
  int samples_sent;
  int quiet_cycles;
  bit tx_steady;
  bit rx_steady;

  sliding_window_average #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .in_last_sample(in_last_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_average   (out_average),
    .out_series_end(out_series_end),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready)
  );

  sliding_window_average_checker #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .in_last_sample (in_last_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_average    (out_average),
    .out_series_end (out_series_end),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .mismatches     (mismatches),
    .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      return 0;
    end else if (pick < 85) begin
      return $urandom_range(1, 3);
    end else if (pick < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] series_value(input int mode, input int idx);
    case (mode)
      5: begin
        return SAMPLE_MAX;
      end
      6: begin
        return SAMPLE_MIN;
      end
      7: begin
        return SAMPLE_BITS'($urandom_range(0, 8) - 4);
      end
      8: begin
        return idx[0] ? SAMPLE_MAX : SAMPLE_MIN;
      end
      9: begin
        return idx[0] ? SAMPLE_MAX - SAMPLE_BITS'($urandom_range(0, 3))
                      : SAMPLE_MIN + SAMPLE_BITS'($urandom_range(0, 3));
      end
      default: begin
        return SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
      end
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] value, input logic last);
    int gap;
    gap = tx_steady ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_sample      <= value;
    in_last_sample <= last;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic cfg_access(input logic write, input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= WL_ADDR;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Drain outstanding averages, then let a sample with no result finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_window(input int wl);
    settle();
    cfg_access(1'b1, CFG_DATA_W'(wl));
    cfg_access(1'b0, '0);
  endtask

  task automatic send_series(input int w);
    int   len;
    int   kind;
    int   mode;
    logic tail;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      len = w + $urandom_range(0, 20);
    end else if (kind < 85) begin
      len = (w > 1) ? $urandom_range(1, w - 1) : 1;
    end else begin
      len = $urandom_range(1, 2 * w + 5);
    end
    mode      = $urandom_range(0, 9);
    tail      = ($urandom_range(0, 99) < 85);
    tx_steady = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < len; i++) begin
      send_sample(series_value(mode, i), tail && (i == len - 1));
    end
  endtask

  initial begin
    int stall_left;
    out_ready  = 1'b0;
    rx_steady  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 2) == 0) begin
          stall_left = idle_gap();
        end
      end
      if ($urandom_range(0, 299) == 0) begin
        rx_steady = !rx_steady;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("sliding_window_average: mismatch");
      $finish;
    end
  end

  initial begin
    int wl;
    int w_eff;
    int phase;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_sample      = '0;
    in_last_sample = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    samples_sent   = 0;
    quiet_cycles   = 0;
    tx_steady      = 1'b0;
    phase          = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    cfg_access(1'b0, '0);

    // reset window of three: saturated sums, truncation, short series
    repeat (4) send_sample(SAMPLE_MAX, 1'b0);
    repeat (3) send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_BITS'(5), 1'b0);
    send_sample(-SAMPLE_BITS'(7), 1'b1);
    send_sample(-SAMPLE_BITS'(1), 1'b0);
    send_sample(-SAMPLE_BITS'(1), 1'b0);
    send_sample('0, 1'b1);
    send_sample(SAMPLE_BITS'(1), 1'b0);
    send_sample(SAMPLE_BITS'(2), 1'b0);
    send_sample(-SAMPLE_BITS'(4), 1'b0);
    send_sample('0, 1'b1);

    // zero length acts as a window of one
    program_window(0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(-SAMPLE_BITS'(1), 1'b1);

    while (samples_sent < TARGET_ITEMS) begin
      if (phase < $size(EDGE_WINDOWS)) begin
        wl = EDGE_WINDOWS[phase];
      end else begin
        case ($urandom_range(0, 9))
          0: wl = 0;
          1: wl = $urandom_range(MAX_WINDOW, (1 << WL_W) - 1);
          2, 3: wl = $urandom_range(9, MAX_WINDOW - 1);
          default: wl = $urandom_range(1, 8);
        endcase
      end
      phase++;
      program_window(wl);
      w_eff = (wl == 0) ? 1 : ((wl > MAX_WINDOW) ? MAX_WINDOW : wl);
      repeat ($urandom_range(1, 4)) send_series(w_eff);
    end

    settle();
    if (mismatches == 0) begin
      $display("sliding_window_average: match");
    end else begin
      $display("sliding_window_average: mismatch");
    end
    $finish;
  end

endmodule
